@@ rtl/arl_pkg.sv @@
// ----------------------------------------------------------------------------
// arl_pkg
// Shared widths, opcodes and request types of the address range table lookup.
// ----------------------------------------------------------------------------
package arl_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int IDX_W       = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = 64;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } rd_req_t;

  typedef struct packed {
    logic              en;
    logic [IDX_W-1:0]  addr;
    logic [ADDR_W-1:0] start_val;
    logic [ADDR_W-1:0] end_val;
  } wr_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start_mid;
    logic [ADDR_W-1:0] start_next;
    logic [ADDR_W-1:0] end_mid;
  } rd_data_t;

endpackage

@@ rtl/arl_store.sv @@
// ----------------------------------------------------------------------------
// arl_store
// Start and end memories. Start has two read ports (entry and its successor),
// end has one; all reads are registered, one write port shared by both.
// ----------------------------------------------------------------------------
module arl_store import arl_pkg::*; (
  input  logic     clk,
  input  wr_req_t  wr_req,
  input  rd_req_t  rd_req,
  output rd_data_t rd_data
);

  logic [ADDR_W-1:0] start_mem [MAX_ENTRIES];
  logic [ADDR_W-1:0] end_mem   [MAX_ENTRIES];
  logic [IDX_W-1:0]  next_addr;

  assign next_addr = rd_req.addr + IDX_W'(1);

  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      start_mem[wr_req.addr] <= wr_req.start_val;
      end_mem[wr_req.addr]   <= wr_req.end_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_req.en) begin
      rd_data.start_mid  <= start_mem[rd_req.addr];
      rd_data.start_next <= start_mem[next_addr];
      rd_data.end_mid    <= end_mem[rd_req.addr];
    end
  end

endmodule

@@ rtl/arl_search.sv @@
// ----------------------------------------------------------------------------
// arl_search
// Request sequencer: writes loads, steps the binary search one probe per
// cycle against the store, and issues the registered result strobe.
// ----------------------------------------------------------------------------
module arl_search import arl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [IDX_W-1:0]  in_load_index,
  input  logic [ADDR_W-1:0] in_range_start,
  input  logic [ADDR_W-1:0] in_range_end,
  input  logic [ADDR_W-1:0] in_query_address,
  input  logic [CNT_W-1:0]  entry_count,
  output wr_req_t           wr_req,
  output rd_req_t           rd_req,
  input  rd_data_t          rd_data,
  output logic              out_valid,
  output logic              out_found,
  output logic [IDX_W-1:0]  out_match_index
);

  typedef enum logic {S_IDLE, S_EVAL} state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi_r, hi_nxt;
  logic [IDX_W-1:0]  mid_r, mid_nxt;
  logic [ADDR_W-1:0] query_r, query_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [IDX_W-1:0]  out_index_r, out_index_nxt;

  logic              accept;
  logic [CNT_W-1:0]  count_sat;
  logic [CNT_W:0]    mid_sum;
  logic [CNT_W-1:0]  mid_plus1;
  logic              go_left;
  logic              go_right;

  assign accept    = start && (state_r == S_IDLE);
  assign count_sat = (entry_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : entry_count;
  assign mid_plus1 = {1'b0, mid_r} + CNT_W'(1);
  assign go_left   = query_r < rd_data.start_mid;
  assign go_right  = (mid_plus1 < hi_r) && (query_r >= rd_data.start_next);
  assign mid_sum   = {1'b0, lo_nxt} + {1'b0, hi_nxt} - (CNT_W + 1)'(1);

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    query_nxt     = query_r;
    out_valid_nxt = 1'b0;
    out_found_nxt = 1'b0;
    out_index_nxt = '0;
    wr_req        = '{en: 1'b0, addr: in_load_index, start_val: in_range_start,
                      end_val: in_range_end};
    rd_req.en     = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_operation == OP_LOAD) begin
            wr_req.en = 1'b1;
          end else begin
            lo_nxt    = '0;
            hi_nxt    = count_sat;
            query_nxt = in_query_address;
            if (count_sat == '0) begin
              out_valid_nxt = 1'b1;
            end else begin
              rd_req.en = 1'b1;
              state_nxt = S_EVAL;
            end
          end
        end
      end
      S_EVAL: begin
        if (go_left) begin
          hi_nxt = {1'b0, mid_r};
        end else if (go_right) begin
          lo_nxt = mid_plus1;
        end
        if (!go_left && !go_right) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = query_r < rd_data.end_mid;
          out_index_nxt = out_found_nxt ? mid_r : '0;
          state_nxt     = S_IDLE;
        end else if (lo_nxt >= hi_nxt) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          rd_req.en = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    mid_nxt     = mid_sum[IDX_W:1];
    rd_req.addr = mid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    query_r     <= query_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
  end

  assign busy            = (state_r != S_IDLE);
  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_index_r;

  a_probe_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (lo_r < hi_r) && ({1'b0, mid_r} >= lo_r) && ({1'b0, mid_r} < hi_r))
    else $error("probe outside search window");

  a_read_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    rd_req.en |=> (state_r == S_EVAL))
    else $error("read issued without evaluation");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_index_r == '0))
    else $error("miss carries nonzero index");

  a_empty_table_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_operation == OP_LOOKUP) && (count_sat == '0))
      |=> (out_valid_r && !out_found_r && (state_r == S_IDLE)))
    else $error("empty table lookup did not miss at once");

  a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_IDLE))
    else $error("result strobe while searching");

endmodule

@@ rtl/address_range_table_lookup_core.sv @@
// ----------------------------------------------------------------------------
// address_range_table_lookup_core
// Sorted address range table with binary-search lookup.
// Load: written to the table when accepted, busy stays low, no result.
// Lookup: one registered memory read per probe, up to ceil(log2(entry_count+1))
//   probes (11 at 1024 entries); result strobe registered after the last probe is evaluated.
// Next request accepted in the strobe cycle.
// Synchronous reset clears control and entry_count; table undefined until loaded.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
module address_range_table_lookup_core import arl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_operation,
  input  logic [IDX_W-1:0]  in_load_index,
  input  logic [ADDR_W-1:0] in_range_start,
  input  logic [ADDR_W-1:0] in_range_end,
  input  logic [ADDR_W-1:0] in_query_address,
  output logic              out_valid,
  output logic              out_found,
  output logic [IDX_W-1:0]  out_match_index,
  input  logic              cfg_we,
  input  logic [CNT_W-1:0]  cfg_wdata
);

  logic [CNT_W-1:0] entry_count_r;
  wr_req_t          wr_req;
  rd_req_t          rd_req;
  rd_data_t         rd_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  arl_store u_store (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  arl_search u_search (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_load_index    (in_load_index),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .in_query_address (in_query_address),
    .entry_count      (entry_count_r),
    .wr_req           (wr_req),
    .rd_req           (rd_req),
    .rd_data          (rd_data),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_match_index  (out_match_index)
  );

endmodule

@@ sim/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench of address_range_table_lookup_core. Loads sorted, empty, inverted
// and unsorted ranges, sweeps the entry count (zero, small, full, saturating)
// and issues lookups around range boundaries. A local range table predicts
// each lookup result, and every result strobe is checked field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import arl_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SEARCH_CYCLES = 16;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } match_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic              in_operation;
  logic [IDX_W-1:0]  in_load_index;
  logic [ADDR_W-1:0] in_range_start;
  logic [ADDR_W-1:0] in_range_end;
  logic [ADDR_W-1:0] in_query_address;
  logic              out_valid;
  logic              out_found;
  logic [IDX_W-1:0]  out_match_index;
  logic              cfg_we;
  logic [CNT_W-1:0]  cfg_wdata;

  logic [ADDR_W-1:0] start_tbl [MAX_ENTRIES];
  logic [ADDR_W-1:0] end_tbl [MAX_ENTRIES];
  logic [CNT_W-1:0]  entry_count_cfg;
  match_t            pending_matches [$];
  int                error_count;
  int                cycle_count;
  int                sender_idle_pct;

  address_range_table_lookup_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_operation     (in_operation),
    .in_load_index    (in_load_index),
    .in_range_start   (in_range_start),
    .in_range_end     (in_range_end),
    .in_query_address (in_query_address),
    .out_valid        (out_valid),
    .out_found        (out_found),
    .out_match_index  (out_match_index),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic match_t find_range(logic [ADDR_W-1:0] q);
    match_t m;
    int n;
    int lo;
    int hi;
    int mid;
    m.found = 1'b0;
    m.index = '0;
    n = entry_count_cfg;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    lo = 0;
    hi = n - 1;
    while (hi >= lo) begin
      mid = lo + (hi - lo) / 2;
      if (q < start_tbl[mid]) begin
        hi = mid - 1;
      end else if (mid < hi && q >= start_tbl[mid + 1]) begin
        lo = mid + 1;
      end else begin
        if (q < end_tbl[mid]) begin
          m.found = 1'b1;
          m.index = IDX_W'(mid);
        end
        break;
      end
    end
    return m;
  endfunction

  function automatic logic [ADDR_W-1:0] make_end(logic [ADDR_W-1:0] s);
    case ($urandom_range(9))
      0: return s;
      1: return s - $urandom_range(1000, 1);
      2: return '1;
      3: return s + (rand64() >> 8);
      default: return s + (rand64() >> $urandom_range(63, 14)) + 1;
    endcase
  endfunction

  // predict on each accepted lookup, record each load, check each result strobe
  always @(posedge clk) begin
    match_t exp_m;
    if (!rst_n) begin
      entry_count_cfg <= '0;
    end else begin
      if (out_valid) begin
        if (pending_matches.size() == 0) begin
          $error("result with no pending lookup: found %0b index %0d",
                 out_found, out_match_index);
          error_count++;
        end else begin
          exp_m = pending_matches.pop_front();
          if (out_found !== exp_m.found) begin
            $error("found mismatch: expected %0b, got %0b", exp_m.found, out_found);
            error_count++;
          end
          if (out_match_index !== exp_m.index) begin
            $error("match_index mismatch: expected %0d, got %0d",
                   exp_m.index, out_match_index);
            error_count++;
          end
        end
      end
      if (cfg_we) entry_count_cfg <= cfg_wdata;
      if (start && !busy) begin
        if (in_operation == OP_LOAD) begin
          start_tbl[in_load_index] = in_range_start;
          end_tbl[in_load_index] = in_range_end;
        end else begin
          pending_matches.push_back(find_range(in_query_address));
        end
      end
    end
  end

  task automatic send_request(logic op, logic [IDX_W-1:0] idx, logic [ADDR_W-1:0] s,
                              logic [ADDR_W-1:0] e, logic [ADDR_W-1:0] q);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    start            <= 1'b1;
    in_operation     <= op;
    in_load_index    <= idx;
    in_range_start   <= s;
    in_range_end     <= e;
    in_query_address <= q;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic load_entry(int idx, logic [ADDR_W-1:0] s, logic [ADDR_W-1:0] e);
    send_request(OP_LOAD, IDX_W'(idx), s, e, rand64());
  endtask

  task automatic lookup(logic [ADDR_W-1:0] q);
    send_request(OP_LOOKUP, IDX_W'($urandom), rand64(), rand64(), q);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_matches.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  task automatic write_entry_count(int value);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic test_empty_table();
    lookup('0);
    lookup('1);
    lookup(64'h8000_0000_0000_0000);
  endtask

  task automatic test_small_table();
    load_entry(0, 64'h100, 64'h200);
    load_entry(1, 64'h300, 64'h300);
    load_entry(2, 64'h500, 64'h400);
    load_entry(3, 64'h800, '1);
    write_entry_count(4);
    lookup(64'h0ff);
    lookup(64'h100);
    lookup(64'h1ff);
    lookup(64'h200);
    lookup(64'h300);
    lookup(64'h480);
    lookup(64'h800);
    lookup(64'hFFFF_FFFF_FFFF_FFFE);
    lookup('1);
    write_entry_count(1);
    lookup(64'h150);
    lookup(64'h800);
  endtask

  task automatic test_fill_table();
    logic [ADDR_W-1:0] s;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      s = {i[IDX_W-1:0], 54'(rand64())};
      if ($urandom_range(7) == 0) s[53:0] = '0;
      load_entry(i, s, make_end(s));
    end
  endtask

  task automatic random_load();
    int idx;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] s;
    idx = $urandom_range(MAX_ENTRIES - 1);
    lo = (idx > 0) ? start_tbl[idx - 1] : '0;
    hi = (idx < MAX_ENTRIES - 1) ? start_tbl[idx + 1] : '1;
    if ($urandom_range(99) < 15 || hi <= lo) s = rand64();
    else s = lo + rand64() % (hi - lo);
    load_entry(idx, s, make_end(s));
  endtask

  task automatic random_lookup();
    int n;
    int k;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] e;
    logic [ADDR_W-1:0] q;
    n = entry_count_cfg;
    if (n > MAX_ENTRIES) n = MAX_ENTRIES;
    k = (n > 0 && $urandom_range(9) != 0) ? $urandom_range(n - 1)
                                           : $urandom_range(MAX_ENTRIES - 1);
    s = start_tbl[k];
    e = end_tbl[k];
    case ($urandom_range(7))
      0: q = s;
      1: q = s - 1;
      2: q = e;
      3: q = e - 1;
      4: q = s + (e - s) / 2;
      5: q = rand64();
      6: q = $urandom_range(1) ? '1 : '0;
      default: q = s + 1;
    endcase
    lookup(q);
  endtask

  task automatic test_random_traffic(int idle_pct, int plan_base);
    int count_plan [12] = '{1024, 0, 2047, 1, 1025, -1, 2, 1023, -1, 3, 512, -1};
    int count;
    sender_idle_pct = idle_pct;
    for (int j = 0; j < 4; j++) begin
      count = count_plan[plan_base + j];
      if (count < 0) count = $urandom_range(1022, 4);
      write_entry_count(count);
      repeat (77) begin
        if ($urandom_range(99) < 30) random_load();
        else random_lookup();
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_operation     <= OP_LOAD;
    in_load_index    <= '0;
    in_range_start   <= '0;
    in_range_end     <= '0;
    in_query_address <= '0;
    cfg_we           <= 1'b0;
    cfg_wdata        <= '0;
    error_count      = 0;
    cycle_count      = 0;
    sender_idle_pct  = 32;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_small_table();
    test_fill_table();
    test_random_traffic(32, 0);
    test_random_traffic(76, 4);
    test_random_traffic(0, 8);

    wait_idle();
    repeat (SEARCH_CYCLES) @(negedge clk);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/arl_pkg.sv
rtl/arl_store.sv
rtl/arl_search.sv
rtl/address_range_table_lookup_core.sv
sim/tb_top.sv
